### hw/rtl/mck_pkg.sv
// ----------------------------------------------------------------------------
// Morse character keyer package
// Shared types, codes, microcode word layout and the character pattern table.
// ----------------------------------------------------------------------------
package mck_pkg;

  localparam int unsigned COUNT_WIDTH   = 16;
  localparam int unsigned CHAR_COUNT_W  = 16;
  localparam int unsigned UNITS_W       = 4;
  localparam int unsigned CODE_W        = 8;
  localparam int unsigned CFG_INDEX_W   = 3;
  localparam int unsigned PAT_LEN_W     = 3;
  localparam int unsigned PAT_BITS_W    = 6;
  localparam int unsigned STEP_W        = 3;

  localparam logic [CODE_W-1:0] FOLD_START   = 8'd97;
  localparam logic [CODE_W-1:0] FOLD_OFFSET  = 8'd32;
  localparam logic [CODE_W-1:0] CODE_SPACE   = 8'd32;
  localparam logic [CODE_W-1:0] CODE_PERCENT = 8'd37;
  localparam logic [CODE_W-1:0] CODE_SLASH   = 8'd47;
  localparam logic [CODE_W-1:0] CODE_ZERO    = 8'd48;

  localparam logic [UNITS_W-1:0] DIT_RESET    = 4'd1;
  localparam logic [UNITS_W-1:0] DAH_RESET    = 4'd3;
  localparam logic [UNITS_W-1:0] GAP_RESET    = 4'd1;
  localparam logic [UNITS_W-1:0] EXTRA_RESET  = 4'd2;
  localparam logic [UNITS_W-1:0] SPACE_RESET  = 4'd4;

  typedef logic [STEP_W-1:0] step_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_DIT   = 3'd0,
    CFG_DAH   = 3'd1,
    CFG_GAP   = 3'd2,
    CFG_EXTRA = 3'd3,
    CFG_SPACE = 3'd4
  } cfg_index_e;

  typedef enum logic [2:0] {
    DUR_ZERO,
    DUR_SPACE,
    DUR_ELEM,
    DUR_GAP,
    DUR_EXTRA
  } dur_sel_e;

  typedef enum logic [1:0] {
    LAST_NONE,
    LAST_ONE,
    LAST_GRP
  } last_sel_e;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_DISPATCH,
    ACT_SHIFT,
    ACT_NEXT_GROUP
  } act_e;

  typedef enum logic [1:0] {
    BR_ALWAYS,
    BR_DISPATCH,
    BR_MORE_ELEM,
    BR_MORE_GROUP
  } branch_e;

  typedef enum logic [1:0] {
    CLS_UNKNOWN,
    CLS_SPACE,
    CLS_GROUP
  } cls_e;

  typedef struct packed {
    logic      emit;
    logic      key_on;
    logic      recognized;
    dur_sel_e  dur_sel;
    last_sel_e last_sel;
    act_e      act;
    branch_e   branch;
    step_t     tgt_t;
    step_t     tgt_f;
  } ucode_t;

  typedef struct packed {
    logic   fire;
    ucode_t cw;
  } ctrl_t;

  typedef struct packed {
    cls_e cls;
    logic more_elem;
    logic more_group;
    logic out_free;
  } status_t;

  // bits: first element in the msb, 1 dah, 0 dit
  typedef struct packed {
    logic [PAT_LEN_W-1:0]  len;
    logic [PAT_BITS_W-1:0] bits;
  } pattern_t;

  function automatic pattern_t char_pattern(logic [CODE_W-1:0] code);
    pattern_t p;
    p = '{len: '0, bits: '0};
    case (code)
      8'd33: p = '{3'd6, 6'b101011};
      8'd34: p = '{3'd6, 6'b010010};
      8'd38: p = '{3'd5, 6'b010000};
      8'd39: p = '{3'd6, 6'b011110};
      8'd40: p = '{3'd5, 6'b101100};
      8'd41: p = '{3'd6, 6'b101101};
      8'd42: p = '{3'd4, 6'b100100};
      8'd43: p = '{3'd5, 6'b010100};
      8'd44: p = '{3'd6, 6'b110011};
      8'd45: p = '{3'd6, 6'b100001};
      8'd46: p = '{3'd6, 6'b010101};
      8'd47: p = '{3'd5, 6'b100100};
      8'd48: p = '{3'd5, 6'b111110};
      8'd49: p = '{3'd5, 6'b011110};
      8'd50: p = '{3'd5, 6'b001110};
      8'd51: p = '{3'd5, 6'b000110};
      8'd52: p = '{3'd5, 6'b000010};
      8'd53: p = '{3'd5, 6'b000000};
      8'd54: p = '{3'd5, 6'b100000};
      8'd55: p = '{3'd5, 6'b110000};
      8'd56: p = '{3'd5, 6'b111000};
      8'd57: p = '{3'd5, 6'b111100};
      8'd58: p = '{3'd6, 6'b111000};
      8'd61: p = '{3'd5, 6'b100010};
      8'd63: p = '{3'd6, 6'b001100};
      8'd64: p = '{3'd6, 6'b011010};
      8'd65: p = '{3'd2, 6'b010000};
      8'd66: p = '{3'd4, 6'b100000};
      8'd67: p = '{3'd4, 6'b101000};
      8'd68: p = '{3'd3, 6'b100000};
      8'd69: p = '{3'd1, 6'b000000};
      8'd70: p = '{3'd4, 6'b001000};
      8'd71: p = '{3'd3, 6'b110000};
      8'd72: p = '{3'd4, 6'b000000};
      8'd73: p = '{3'd2, 6'b000000};
      8'd74: p = '{3'd4, 6'b011100};
      8'd75: p = '{3'd3, 6'b101000};
      8'd76: p = '{3'd4, 6'b010000};
      8'd77: p = '{3'd2, 6'b110000};
      8'd78: p = '{3'd2, 6'b100000};
      8'd79: p = '{3'd3, 6'b111000};
      8'd80: p = '{3'd4, 6'b011000};
      8'd81: p = '{3'd4, 6'b110100};
      8'd82: p = '{3'd3, 6'b010000};
      8'd83: p = '{3'd3, 6'b000000};
      8'd84: p = '{3'd1, 6'b100000};
      8'd85: p = '{3'd3, 6'b001000};
      8'd86: p = '{3'd4, 6'b000100};
      8'd87: p = '{3'd3, 6'b011000};
      8'd88: p = '{3'd4, 6'b100100};
      8'd89: p = '{3'd4, 6'b101100};
      8'd90: p = '{3'd4, 6'b110000};
      default: p = '{len: '0, bits: '0};
    endcase
    return p;
  endfunction

endpackage

### hw/rtl/mck_sequencer.sv
// ----------------------------------------------------------------------------
// Morse character keyer sequencer
// Step counter and microcode table; issues one control word per cycle.
// ----------------------------------------------------------------------------
module mck_sequencer (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  mck_pkg::status_t status_i,
  output mck_pkg::ctrl_t   ctrl_o
);

  localparam mck_pkg::step_t S_FETCH = 3'd0;
  localparam mck_pkg::step_t S_UNK   = 3'd1;
  localparam mck_pkg::step_t S_SPC   = 3'd2;
  localparam mck_pkg::step_t S_MARK  = 3'd3;
  localparam mck_pkg::step_t S_GAP   = 3'd4;
  localparam mck_pkg::step_t S_LEND  = 3'd5;

  localparam int unsigned NUM_STEPS = 2 ** mck_pkg::STEP_W;

  // emit, key, rec, duration, last, action, branch, taken, not taken
  localparam mck_pkg::ucode_t UCODE [NUM_STEPS] = '{
    '{1'b0, 1'b0, 1'b0, mck_pkg::DUR_ZERO,  mck_pkg::LAST_NONE, mck_pkg::ACT_DISPATCH,
      mck_pkg::BR_DISPATCH,   S_FETCH, S_FETCH},
    '{1'b1, 1'b0, 1'b0, mck_pkg::DUR_ZERO,  mck_pkg::LAST_ONE,  mck_pkg::ACT_NONE,
      mck_pkg::BR_ALWAYS,     S_FETCH, S_FETCH},
    '{1'b1, 1'b0, 1'b1, mck_pkg::DUR_SPACE, mck_pkg::LAST_ONE,  mck_pkg::ACT_NONE,
      mck_pkg::BR_ALWAYS,     S_FETCH, S_FETCH},
    '{1'b1, 1'b1, 1'b1, mck_pkg::DUR_ELEM,  mck_pkg::LAST_NONE, mck_pkg::ACT_NONE,
      mck_pkg::BR_ALWAYS,     S_GAP,   S_GAP},
    '{1'b1, 1'b0, 1'b1, mck_pkg::DUR_GAP,   mck_pkg::LAST_NONE, mck_pkg::ACT_SHIFT,
      mck_pkg::BR_MORE_ELEM,  S_MARK,  S_LEND},
    '{1'b1, 1'b0, 1'b1, mck_pkg::DUR_EXTRA, mck_pkg::LAST_GRP,  mck_pkg::ACT_NEXT_GROUP,
      mck_pkg::BR_MORE_GROUP, S_MARK,  S_FETCH},
    '{1'b0, 1'b0, 1'b0, mck_pkg::DUR_ZERO,  mck_pkg::LAST_NONE, mck_pkg::ACT_NONE,
      mck_pkg::BR_ALWAYS,     S_FETCH, S_FETCH},
    '{1'b0, 1'b0, 1'b0, mck_pkg::DUR_ZERO,  mck_pkg::LAST_NONE, mck_pkg::ACT_NONE,
      mck_pkg::BR_ALWAYS,     S_FETCH, S_FETCH}
  };

  mck_pkg::step_t  step_q, step_d;
  mck_pkg::ucode_t cw;
  logic            fire;

  assign cw = UCODE[step_q];

  always_comb begin
    if (cw.act == mck_pkg::ACT_DISPATCH) begin
      fire = in_valid_i;
    end else begin
      fire = !cw.emit || status_i.out_free;
    end
  end

  always_comb begin
    step_d = step_q;
    if (fire) begin
      unique case (cw.branch)
        mck_pkg::BR_ALWAYS: step_d = cw.tgt_t;
        mck_pkg::BR_DISPATCH: begin
          unique case (status_i.cls)
            mck_pkg::CLS_UNKNOWN: step_d = S_UNK;
            mck_pkg::CLS_SPACE:   step_d = S_SPC;
            default:              step_d = S_MARK;
          endcase
        end
        mck_pkg::BR_MORE_ELEM:  step_d = status_i.more_elem  ? cw.tgt_t : cw.tgt_f;
        mck_pkg::BR_MORE_GROUP: step_d = status_i.more_group ? cw.tgt_t : cw.tgt_f;
        default:                step_d = S_FETCH;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= S_FETCH;
    end else begin
      step_q <= step_d;
    end
  end

  assign in_ready_o  = (cw.act == mck_pkg::ACT_DISPATCH);
  assign ctrl_o.fire = fire;
  assign ctrl_o.cw   = cw;

  // a character request is only taken at the fetch step
  a_ready_at_fetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> step_q == S_FETCH)
    else $error("input ready outside fetch step");

  // an unknown character goes straight to its single result step
  a_unknown_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && status_i.cls == mck_pkg::CLS_UNKNOWN) |=> step_q == S_UNK)
    else $error("unknown character not routed to its result step");

  // the element gap step never falls through to the fetch step directly
  a_gap_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == S_GAP && fire) |=> (step_q == S_MARK || step_q == S_LEND))
    else $error("gap step left to an unexpected step");

endmodule

### hw/rtl/mck_datapath.sv
// ----------------------------------------------------------------------------
// Morse character keyer datapath
// Timing registers, pattern shifter, group and character counters, result register.
// ----------------------------------------------------------------------------
module mck_datapath #(
  parameter int unsigned CountWidth = mck_pkg::COUNT_WIDTH
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  mck_pkg::ctrl_t                       ctrl_i,
  output mck_pkg::status_t                     status_o,
  input  logic                                 cfg_valid_i,
  input  logic [mck_pkg::CFG_INDEX_W-1:0]      cfg_index_i,
  input  logic [mck_pkg::UNITS_W-1:0]          cfg_data_i,
  input  logic [mck_pkg::CODE_W-1:0]           char_code_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic                                 key_on_o,
  output logic [mck_pkg::UNITS_W-1:0]          duration_units_o,
  output logic                                 recognized_o,
  output logic [mck_pkg::CHAR_COUNT_W-1:0]     char_count_o,
  output logic                                 last_o
);

  localparam int unsigned CW = mck_pkg::CHAR_COUNT_W;

  logic [mck_pkg::UNITS_W-1:0] dit_q, dah_q, gap_q, extra_q, space_q;
  logic [mck_pkg::UNITS_W-1:0] dit_d, dah_d, gap_d, extra_d, space_d;

  logic [CountWidth-1:0]             count_q, count_d;
  logic [1:0]                        grp_q, grp_d;
  logic [mck_pkg::PAT_LEN_W-1:0]     len_q, len_d;
  logic [mck_pkg::PAT_BITS_W-1:0]    pat_q, pat_d;
  logic                              out_valid_q, out_valid_d;
  logic                              key_q, rec_q, last_q;
  logic [mck_pkg::UNITS_W-1:0]       dur_q;
  logic [CW-1:0]                     cnt_q;

  logic [mck_pkg::CODE_W-1:0] folded;
  logic                       is_space, is_pct;
  mck_pkg::pattern_t          in_pat, zero_pat, slash_pat, load_pat;
  mck_pkg::cls_e              cls;
  logic                       emit_fire, act_fire;
  logic [mck_pkg::UNITS_W-1:0] dur_sel;
  logic                       last_sel;
  logic [CW-1:0]              cnt_low;

  // character decode
  assign folded    = (char_code_i >= mck_pkg::FOLD_START) ?
                     (char_code_i - mck_pkg::FOLD_OFFSET) : char_code_i;
  assign is_space  = (folded == mck_pkg::CODE_SPACE);
  assign is_pct    = (folded == mck_pkg::CODE_PERCENT);
  assign in_pat    = mck_pkg::char_pattern(folded);
  assign zero_pat  = mck_pkg::char_pattern(mck_pkg::CODE_ZERO);
  assign slash_pat = mck_pkg::char_pattern(mck_pkg::CODE_SLASH);

  always_comb begin
    if (is_space) begin
      cls = mck_pkg::CLS_SPACE;
    end else if (is_pct || (in_pat.len != '0)) begin
      cls = mck_pkg::CLS_GROUP;
    end else begin
      cls = mck_pkg::CLS_UNKNOWN;
    end
  end

  assign emit_fire = ctrl_i.fire && ctrl_i.cw.emit;
  assign act_fire  = ctrl_i.fire;

  // timing registers
  always_comb begin
    dit_d   = dit_q;
    dah_d   = dah_q;
    gap_d   = gap_q;
    extra_d = extra_q;
    space_d = space_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        mck_pkg::CFG_DIT:   dit_d   = cfg_data_i;
        mck_pkg::CFG_DAH:   dah_d   = cfg_data_i;
        mck_pkg::CFG_GAP:   gap_d   = cfg_data_i;
        mck_pkg::CFG_EXTRA: extra_d = cfg_data_i;
        mck_pkg::CFG_SPACE: space_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  // pattern, group and character counters
  always_comb begin
    count_d  = count_q;
    grp_d    = grp_q;
    len_d    = len_q;
    pat_d    = pat_q;
    load_pat = is_pct ? zero_pat : in_pat;
    if (act_fire) begin
      unique case (ctrl_i.cw.act)
        mck_pkg::ACT_DISPATCH: begin
          len_d = load_pat.len;
          pat_d = load_pat.bits;
          grp_d = is_pct ? 2'd2 : 2'd0;
          if ((cls != mck_pkg::CLS_UNKNOWN) && (count_q != '1)) begin
            count_d = count_q + CountWidth'(1);
          end
        end
        mck_pkg::ACT_SHIFT: begin
          len_d = len_q - mck_pkg::PAT_LEN_W'(1);
          pat_d = pat_q << 1;
        end
        mck_pkg::ACT_NEXT_GROUP: begin
          if (grp_q != 2'd0) begin
            len_d = (grp_q == 2'd2) ? slash_pat.len  : zero_pat.len;
            pat_d = (grp_q == 2'd2) ? slash_pat.bits : zero_pat.bits;
            grp_d = grp_q - 2'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // result fields
  always_comb begin
    unique case (ctrl_i.cw.dur_sel)
      mck_pkg::DUR_ZERO:  dur_sel = '0;
      mck_pkg::DUR_SPACE: dur_sel = space_q;
      mck_pkg::DUR_ELEM:  dur_sel = pat_q[mck_pkg::PAT_BITS_W-1] ? dah_q : dit_q;
      mck_pkg::DUR_GAP:   dur_sel = gap_q;
      mck_pkg::DUR_EXTRA: dur_sel = extra_q;
      default:            dur_sel = '0;
    endcase
  end

  always_comb begin
    unique case (ctrl_i.cw.last_sel)
      mck_pkg::LAST_NONE: last_sel = 1'b0;
      mck_pkg::LAST_ONE:  last_sel = 1'b1;
      mck_pkg::LAST_GRP:  last_sel = (grp_q == 2'd0);
      default:            last_sel = 1'b0;
    endcase
  end

  if (CountWidth >= CW) begin : g_cnt_trunc
    assign cnt_low = count_q[CW-1:0];
  end else begin : g_cnt_ext
    assign cnt_low = {{(CW - CountWidth){1'b0}}, count_q};
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit_fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dit_q       <= mck_pkg::DIT_RESET;
      dah_q       <= mck_pkg::DAH_RESET;
      gap_q       <= mck_pkg::GAP_RESET;
      extra_q     <= mck_pkg::EXTRA_RESET;
      space_q     <= mck_pkg::SPACE_RESET;
      count_q     <= '0;
      grp_q       <= '0;
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      dit_q       <= dit_d;
      dah_q       <= dah_d;
      gap_q       <= gap_d;
      extra_q     <= extra_d;
      space_q     <= space_d;
      count_q     <= count_d;
      grp_q       <= grp_d;
      len_q       <= len_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pat_q <= pat_d;
    if (emit_fire) begin
      key_q  <= ctrl_i.cw.key_on;
      dur_q  <= dur_sel;
      rec_q  <= ctrl_i.cw.recognized;
      cnt_q  <= cnt_low;
      last_q <= last_sel;
    end
  end

  assign status_o.cls        = cls;
  assign status_o.more_elem  = (len_q != {{(mck_pkg::PAT_LEN_W-1){1'b0}}, 1'b1});
  assign status_o.more_group = (grp_q != 2'd0);
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o      = out_valid_q;
  assign key_on_o         = key_q;
  assign duration_units_o = dur_q;
  assign recognized_o     = rec_q;
  assign char_count_o     = cnt_q;
  assign last_o           = last_q;

  // the recognized counter never moves backward
  a_count_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q >= $past(count_q))
    else $error("character counter decreased");

  // a dit or dah is only keyed while elements remain
  a_elem_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.cw.dur_sel == mck_pkg::DUR_ELEM) |-> len_q != '0)
    else $error("element keyed with empty pattern");

  // both follow-on groups of a percent sign have five elements
  a_next_group_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (act_fire && ctrl_i.cw.act == mck_pkg::ACT_NEXT_GROUP && grp_q != 2'd0)
      |=> len_q == mck_pkg::PAT_LEN_W'(5))
    else $error("follow-on group loaded with wrong length");

endmodule

### hw/rtl/morse_character_keyer.sv
// ----------------------------------------------------------------------------
// Morse character keyer
// Turns one character request into a run of key-down and key-up intervals.
// ----------------------------------------------------------------------------
// Each accepted character produces between 1 and 33 results, one per cycle
// while the consumer is ready, after the fetch step that takes it (a letter
// with k elements gives 2k + 1 results, a percent sign gives 33). The order is
// set by the microcode sequencer, which walks one step per interval and returns
// to its fetch step before the next character is taken; a stalled consumer
// holds the sequence at the current step. Timing registers may be written at
// any time the block is idle and take effect on the next character.
module morse_character_keyer #(
  parameter int unsigned CountWidth = mck_pkg::COUNT_WIDTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [mck_pkg::CODE_W-1:0]        char_code_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              key_on_o,
  output logic [mck_pkg::UNITS_W-1:0]       duration_units_o,
  output logic                              recognized_o,
  output logic [mck_pkg::CHAR_COUNT_W-1:0]  char_count_o,
  output logic                              last_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [mck_pkg::CFG_INDEX_W-1:0]   cfg_index_i,
  input  logic [mck_pkg::UNITS_W-1:0]       cfg_data_i
);

  mck_pkg::ctrl_t   ctrl;
  mck_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  mck_sequencer u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .ctrl_o     (ctrl)
  );

  mck_datapath #(
    .CountWidth (CountWidth)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctrl_i           (ctrl),
    .status_o         (status),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .char_code_i      (char_code_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .key_on_o         (key_on_o),
    .duration_units_o (duration_units_o),
    .recognized_o     (recognized_o),
    .char_count_o     (char_count_o),
    .last_o           (last_o)
  );

endmodule
